// ===== hw/rtl/hsf_pkg.sv =====
package hsf_pkg;

  // widths of the item fields
  localparam int BYTE_BITS   = 8;
  localparam int TEMP_BITS   = 15;
  localparam int HUM_BITS    = 14;
  localparam int RUN_BITS    = 4;
  localparam int STATUS_BITS = 2;
  localparam int TOTAL_BITS  = 32;

  // configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 15;

  // counter width default
  localparam int COUNT_BITS_DEF = 32;

  // crc and raw word handling
  localparam logic [8:0]  CRC_POLY = 9'h131;
  localparam logic [15:0] RAW_MASK = 16'hFFFC;

  // fixed point scaling: value = offset + (scale * raw) >> 16
  localparam logic [14:0]        T_SCALE  = 15'd17572;
  localparam logic signed [15:0] T_OFFSET = -16'sd4685;
  localparam logic [13:0]        H_SCALE  = 14'd12500;
  localparam logic signed [15:0] H_OFFSET = -16'sd600;
  localparam logic [13:0]        H_MAX    = 14'd10000;

  // register reset values
  localparam logic [13:0]        JUMP_LIMIT_RST = 14'd300;
  localparam logic [3:0]         MAX_RUN_RST    = 4'd3;
  localparam logic signed [14:0] TEMP_MIN_RST   = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX_RST   = 15'sd12500;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_JUMP_LIMIT = 2'd0,
    CFG_MAX_RUN    = 2'd1,
    CFG_TEMP_MIN   = 2'd2,
    CFG_TEMP_MAX   = 2'd3
  } cfg_idx_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [13:0]        jump_limit;
    logic [3:0]         max_run;
    logic signed [14:0] temp_min;
    logic signed [14:0] temp_max;
  } cfg_t;

  // one input item, last declared field lowest
  typedef struct packed {
    logic [7:0] hum_check;
    logic [7:0] hum_lsb;
    logic [7:0] hum_msb;
    logic [7:0] temp_check;
    logic [7:0] temp_lsb;
    logic [7:0] temp_msb;
  } sample_t;

  localparam int IN_BITS = $bits(sample_t);

  // converted reading handed from conversion to filter
  typedef struct packed {
    status_t            status;
    logic signed [14:0] temp;
    logic [13:0]        hum;
  } conv_t;

  // one result item, last declared field lowest
  typedef struct packed {
    logic [TOTAL_BITS-1:0] samples_seen;
    logic [TOTAL_BITS-1:0] errors_seen;
    logic [TOTAL_BITS-1:0] anomalies_seen;
    logic [RUN_BITS-1:0]   anomaly_run;
    logic                  held_last;
    logic [HUM_BITS-1:0]   humidity_centi;
    logic signed [14:0]    temperature_centi;
    status_t               status;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int OUT_BITS    = ((RESULT_BITS + 7) / 8) * 8;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY[7:0]) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
    return crc8_byte(crc8_byte(8'h00, hi), lo);
  endfunction

endpackage

// ===== hw/rtl/hsf_convert.sv =====
module hsf_convert (
  input  hsf_pkg::sample_t sample,
  input  hsf_pkg::cfg_t    cfg,
  output hsf_pkg::conv_t   conv
);

  logic [15:0]        t_raw;
  logic [15:0]        h_raw;
  logic [30:0]        t_prod;
  logic [29:0]        h_prod;
  logic signed [15:0] t_wide;
  logic signed [15:0] h_wide;
  logic signed [14:0] t_val;
  logic [13:0]        h_val;
  logic               t_crc_ok;
  logic               h_crc_ok;

  assign t_crc_ok = (hsf_pkg::crc8_word(sample.temp_msb, sample.temp_lsb) == sample.temp_check);
  assign h_crc_ok = (hsf_pkg::crc8_word(sample.hum_msb, sample.hum_lsb) == sample.hum_check);

  // status bits of the low byte are dropped
  assign t_raw = {sample.temp_msb, sample.temp_lsb} & hsf_pkg::RAW_MASK;
  assign h_raw = {sample.hum_msb, sample.hum_lsb} & hsf_pkg::RAW_MASK;

  assign t_prod = 31'(t_raw) * 31'(hsf_pkg::T_SCALE);
  assign h_prod = 30'(h_raw) * 30'(hsf_pkg::H_SCALE);

  assign t_wide = signed'({1'b0, t_prod[30:16]}) + hsf_pkg::T_OFFSET;
  assign h_wide = signed'({2'b00, h_prod[29:16]}) + hsf_pkg::H_OFFSET;

  assign t_val = t_wide[14:0];

  always_comb begin
    if (h_wide < 16'sd0) begin
      h_val = '0;
    end else if (h_wide > signed'({2'b00, hsf_pkg::H_MAX})) begin
      h_val = hsf_pkg::H_MAX;
    end else begin
      h_val = h_wide[13:0];
    end
  end

  always_comb begin
    conv.temp = t_val;
    conv.hum  = h_val;
    priority if (!t_crc_ok) begin
      conv.status = hsf_pkg::STATUS_TEMP_CRC;
    end else if (!h_crc_ok) begin
      conv.status = hsf_pkg::STATUS_HUM_CRC;
    end else if (t_val < cfg.temp_min || t_val > cfg.temp_max) begin
      conv.status = hsf_pkg::STATUS_RANGE;
    end else begin
      conv.status = hsf_pkg::STATUS_OK;
    end
  end

endmodule

// ===== hw/rtl/hsf_filter.sv =====
module hsf_filter #(
  parameter int COUNT_BITS = hsf_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hsf_pkg::conv_t   conv,
  input  hsf_pkg::cfg_t    cfg,
  output hsf_pkg::result_t result
);

  logic                  have_good_r, have_good_nxt;
  logic signed [14:0]    last_temp_r, last_temp_nxt;
  logic [13:0]           last_hum_r, last_hum_nxt;
  logic [3:0]            run_r, run_nxt;
  logic [COUNT_BITS-1:0] anom_cnt_r, anom_cnt_nxt;
  logic [COUNT_BITS-1:0] err_cnt_r, err_cnt_nxt;
  logic [COUNT_BITS-1:0] samp_cnt_r, samp_cnt_nxt;
  logic                  held_nxt;
  hsf_pkg::result_t      result_r;

  logic signed [16:0] dt;
  logic [16:0]        dt_mag;
  logic signed [14:0] dh;
  logic [14:0]        dh_mag;
  logic [4:0]         run_inc;
  logic               jump;

  assign dt     = 17'(conv.temp) - 17'(last_temp_r);
  assign dt_mag = dt[16] ? 17'(-dt) : 17'(dt);
  assign dh     = signed'({1'b0, conv.hum}) - signed'({1'b0, last_hum_r});
  assign dh_mag = dh[14] ? 15'(-dh) : 15'(dh);
  assign jump   = (dt_mag > 17'(cfg.jump_limit)) || (dh_mag > 15'(cfg.jump_limit));
  assign run_inc = 5'(run_r) + 5'd1;

  always_comb begin
    have_good_nxt = have_good_r;
    last_temp_nxt = last_temp_r;
    last_hum_nxt  = last_hum_r;
    run_nxt       = run_r;
    anom_cnt_nxt  = anom_cnt_r;
    err_cnt_nxt   = err_cnt_r;
    samp_cnt_nxt  = samp_cnt_r + 1'b1;
    held_nxt      = 1'b0;
    priority if (conv.status != hsf_pkg::STATUS_OK) begin
      err_cnt_nxt = err_cnt_r + 1'b1;
    end else if (!have_good_r) begin
      // first good pair skips the spike test
      have_good_nxt = 1'b1;
      last_temp_nxt = conv.temp;
      last_hum_nxt  = conv.hum;
    end else if (jump) begin
      anom_cnt_nxt = anom_cnt_r + 1'b1;
      if (run_inc > 5'(cfg.max_run)) begin
        run_nxt       = '0;
        last_temp_nxt = conv.temp;
        last_hum_nxt  = conv.hum;
      end else begin
        run_nxt  = run_inc[3:0];
        held_nxt = 1'b1;
      end
    end else begin
      run_nxt       = '0;
      last_temp_nxt = conv.temp;
      last_hum_nxt  = conv.hum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_good_r <= 1'b0;
      last_temp_r <= '0;
      last_hum_r  <= '0;
      run_r       <= '0;
      anom_cnt_r  <= '0;
      err_cnt_r   <= '0;
      samp_cnt_r  <= '0;
    end else if (load) begin
      have_good_r <= have_good_nxt;
      last_temp_r <= last_temp_nxt;
      last_hum_r  <= last_hum_nxt;
      run_r       <= run_nxt;
      anom_cnt_r  <= anom_cnt_nxt;
      err_cnt_r   <= err_cnt_nxt;
      samp_cnt_r  <= samp_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r.status            <= conv.status;
      result_r.temperature_centi <= last_temp_nxt;
      result_r.humidity_centi    <= last_hum_nxt;
      result_r.held_last         <= held_nxt;
      result_r.anomaly_run       <= run_nxt;
      result_r.anomalies_seen    <= 32'(anom_cnt_nxt);
      result_r.errors_seen       <= 32'(err_cnt_nxt);
      result_r.samples_seen      <= 32'(samp_cnt_nxt);
    end
  end

  assign result = result_r;

endmodule

// ===== hw/rtl/humidity_sensor_sample_filter.sv =====
// humidity and temperature sample filter. each input item carries one
// temperature frame and one humidity frame (high byte, low byte, crc-8 byte).
// both frames are checked with crc-8 (poly 0x131, init 0), the raw words are
// scaled to hundredths of a degree and of a percent, the temperature is
// checked against temp_min..temp_max, and a spike filter holds
// the last good pair when either value jumps by more than jump_limit,
// until more than max_run anomalies come in a row. every item gives exactly
// one result item. throughput is one item per clock while the output is not
// stalled; the path runs through an input register, a conversion register
// after crc and constant multiply, and a result register after the spike
// filter. the filter state updates once per item in the last stage,
// so back-to-back items see each other's state in order. configuration
// registers are written through cfg_we/cfg_addr/cfg_wdata and should only
// change while no item is in flight. totals are COUNT_BITS wide and wrap;
// their low 32 bits are reported.
module humidity_sensor_sample_filter #(
  parameter int COUNT_BITS = hsf_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb, hum_check
  input  logic [hsf_pkg::IN_BITS-1:0]         in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, temperature_centi, humidity_centi, held_last, anomaly_run,
  // anomalies_seen, errors_seen, samples_seen, zero pad
  output logic [hsf_pkg::OUT_BITS-1:0]        out_tdata,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [hsf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [hsf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  // configuration registers
  hsf_pkg::cfg_t cfg_r;

  // stage 1: registered input item
  logic             s1_valid_r;
  hsf_pkg::sample_t s1_data_r;

  // stage 2: registered conversion
  logic             s2_valid_r;
  hsf_pkg::conv_t   s2_conv_r;
  hsf_pkg::conv_t   conv;

  // result stage
  logic             out_valid_r;
  hsf_pkg::result_t result;

  // stage handshake: a stage may load when it is empty or moving on
  logic out_free;
  logic s2_free;
  logic s2_adv;
  logic s1_adv;
  logic in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_adv    = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_limit <= hsf_pkg::JUMP_LIMIT_RST;
      cfg_r.max_run    <= hsf_pkg::MAX_RUN_RST;
      cfg_r.temp_min   <= hsf_pkg::TEMP_MIN_RST;
      cfg_r.temp_max   <= hsf_pkg::TEMP_MAX_RST;
    end else if (cfg_we) begin
      unique case (hsf_pkg::cfg_idx_t'(cfg_addr))
        hsf_pkg::CFG_JUMP_LIMIT: cfg_r.jump_limit <= cfg_wdata[13:0];
        hsf_pkg::CFG_MAX_RUN:    cfg_r.max_run    <= cfg_wdata[3:0];
        hsf_pkg::CFG_TEMP_MIN:   cfg_r.temp_min   <= signed'(cfg_wdata);
        hsf_pkg::CFG_TEMP_MAX:   cfg_r.temp_max   <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= hsf_pkg::sample_t'(in_tdata);
    end
    if (s1_adv) begin
      s2_conv_r <= conv;
    end
  end

  // crc check, scaling and range check
  hsf_convert u_convert (
    .sample (s1_data_r),
    .cfg    (cfg_r),
    .conv   (conv)
  );

  // spike filter, totals and result register
  hsf_filter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s2_adv),
    .conv   (s2_conv_r),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = hsf_pkg::OUT_BITS'(result);

endmodule

// ===== hw/rtl/hsf_checker.sv =====
module hsf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [hsf_pkg::OUT_BITS-1:0] out_tdata
);

  hsf_pkg::result_t res;

  assign res = hsf_pkg::result_t'(out_tdata[hsf_pkg::RESULT_BITS-1:0]);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a held pair comes only from a clean reading inside an anomaly run
  a_held_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.held_last |->
      res.status == hsf_pkg::STATUS_OK && res.anomaly_run != 4'd0)
    else $error("held pair without a clean reading and a running anomaly count");

  // error items never report a hold
  a_err_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.status != hsf_pkg::STATUS_OK |-> !res.held_last)
    else $error("error item flagged as held");

  // reported humidity stays clamped
  a_hum_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.humidity_centi <= hsf_pkg::H_MAX)
    else $error("humidity above full scale");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind humidity_sensor_sample_filter hsf_checker u_hsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/humidity_sensor_sample_filter_tb.sv =====
module humidity_sensor_sample_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no item moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // pause after the last result
  localparam int TAIL_CYCLES = 12;

  // receiver behavior, switched at random between the modes below
  typedef enum logic [1:0] {
    RX_OPEN,   // always ready
    RX_COIN,   // ready half the time
    RX_CHOKE   // ready a quarter of the time
  } rx_mode_t;

  // one directed item: raw words, crc corruption, and optionally pinned results
  typedef struct {
    logic [15:0]      t_word;
    logic [15:0]      h_word;
    logic [7:0]       t_flip;
    logic [7:0]       h_flip;
    bit               fixed;
    hsf_pkg::status_t st;
    int               temp;
    int               hum;
  } stim_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [hsf_pkg::IN_BITS-1:0]       in_tdata;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [hsf_pkg::OUT_BITS-1:0]      out_tdata;
  logic                              cfg_we;
  logic [hsf_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [hsf_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  humidity_sensor_sample_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // filter model state, mirrors the block from reset on
  // ---------------------------------------------------------------------
  logic [13:0]        jump_lim = hsf_pkg::JUMP_LIMIT_RST;
  logic [3:0]         run_cap  = hsf_pkg::MAX_RUN_RST;
  logic signed [14:0] t_lo     = hsf_pkg::TEMP_MIN_RST;
  logic signed [14:0] t_hi     = hsf_pkg::TEMP_MAX_RST;

  bit          have_good     = 1'b0;
  int          last_t        = 0;
  int          last_h        = 0;
  logic [3:0]  run_len       = '0;
  logic [31:0] anomaly_total = '0;
  logic [31:0] error_total   = '0;
  logic [31:0] sample_total  = '0;

  hsf_pkg::result_t pending_readings[$];   // expected result items, oldest first
  stim_row_t        pinned_values[$];      // one tag per presented item
  int        failures    = 0;
  int        idle_cycles = 0;
  int        burst_left  = 0;
  logic [15:0] walk_t = 16'h8000;
  logic [15:0] walk_h = 16'h8000;

  rx_mode_t ready_mode = RX_OPEN;
  int       mode_left  = 0;

  // crc-8 over hi then lo, msb first, init zero
  function automatic logic [7:0] frame_crc(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] w;
    logic [7:0]  c;
    w = {hi, lo};
    c = 8'h00;
    for (int i = 15; i >= 0; i--) begin
      if (c[7] ^ w[i]) c = (c << 1) ^ hsf_pkg::CRC_POLY[7:0];
      else c = c << 1;
    end
    return c;
  endfunction

  // build an input item with correct check bytes, then xor in the corruption
  function automatic hsf_pkg::sample_t frame_item(logic [15:0] tw, logic [15:0] hw,
                                                  logic [7:0] t_flip, logic [7:0] h_flip);
    hsf_pkg::sample_t s;
    s.temp_msb   = tw[15:8];
    s.temp_lsb   = tw[7:0];
    s.temp_check = frame_crc(tw[15:8], tw[7:0]) ^ t_flip;
    s.hum_msb    = hw[15:8];
    s.hum_lsb    = hw[7:0];
    s.hum_check  = frame_crc(hw[15:8], hw[7:0]) ^ h_flip;
    return s;
  endfunction

  // advance the filter model by one item and give the reading it reports
  function automatic hsf_pkg::result_t predict_reading(hsf_pkg::sample_t s);
    hsf_pkg::result_t r;
    hsf_pkg::status_t stat;
    logic [15:0]      raw_t, raw_h;
    int               t_val, h_val, lim;
    bit               held;
    stat  = hsf_pkg::STATUS_OK;
    held  = 1'b0;
    t_val = 0;
    h_val = 0;
    sample_total = sample_total + 1;
    if (frame_crc(s.temp_msb, s.temp_lsb) != s.temp_check) begin
      stat = hsf_pkg::STATUS_TEMP_CRC;
    end else if (frame_crc(s.hum_msb, s.hum_lsb) != s.hum_check) begin
      stat = hsf_pkg::STATUS_HUM_CRC;
    end else begin
      // two status bits at the bottom of each word are dropped
      raw_t = {s.temp_msb, s.temp_lsb} & hsf_pkg::RAW_MASK;
      raw_h = {s.hum_msb, s.hum_lsb} & hsf_pkg::RAW_MASK;
      t_val = int'(hsf_pkg::T_OFFSET) +
              int'((longint'(hsf_pkg::T_SCALE) * longint'(raw_t)) >> 16);
      h_val = int'(hsf_pkg::H_OFFSET) +
              int'((longint'(hsf_pkg::H_SCALE) * longint'(raw_h)) >> 16);
      if (h_val < 0) h_val = 0;
      if (h_val > int'(hsf_pkg::H_MAX)) h_val = int'(hsf_pkg::H_MAX);
      if (t_val < int'(t_lo) || t_val > int'(t_hi)) stat = hsf_pkg::STATUS_RANGE;
    end

    if (stat != hsf_pkg::STATUS_OK) begin
      error_total = error_total + 1;
    end else if (!have_good) begin
      // first good pair goes straight in, no spike test
      have_good = 1'b1;
      last_t = t_val;
      last_h = h_val;
    end else begin
      lim = int'(jump_lim);
      if ((t_val > last_t ? t_val - last_t : last_t - t_val) > lim ||
          (h_val > last_h ? h_val - last_h : last_h - h_val) > lim) begin
        anomaly_total = anomaly_total + 1;
        if (int'(run_len) + 1 > int'(run_cap)) begin
          // run too long: the jump is real, take it
          run_len = '0;
          last_t  = t_val;
          last_h  = h_val;
        end else begin
          run_len = run_len + 1;
          held    = 1'b1;
        end
      end else begin
        run_len = '0;
        last_t  = t_val;
        last_h  = h_val;
      end
    end

    r.status            = stat;
    r.temperature_centi = last_t[14:0];
    r.humidity_centi    = last_h[13:0];
    r.held_last         = held;
    r.anomaly_run       = run_len;
    r.anomalies_seen    = anomaly_total;
    r.errors_seen       = error_total;
    r.samples_seen      = sample_total;
    return r;
  endfunction

  task automatic compare_field(string fname, longint want, longint got);
    if (want != got) begin
      failures++;
      $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // receiver: stall pattern switches between open, coin-flip and choked
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_mode <= RX_OPEN;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= rx_mode_t'($urandom_range(0, 2));
        mode_left  <= $urandom_range(10, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // predict on input accept, compare on output accept
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    hsf_pkg::result_t want_r;
    hsf_pkg::result_t got_r;
    stim_row_t        tag;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want_r = predict_reading(hsf_pkg::sample_t'(in_tdata));
        tag = pinned_values.pop_front();
        // pinned values are typed in by hand and replace the model's
        if (tag.fixed) begin
          want_r.status            = tag.st;
          want_r.temperature_centi = tag.temp[14:0];
          want_r.humidity_centi    = tag.hum[13:0];
        end
        pending_readings.push_back(want_r);
      end
      if (out_tvalid && out_tready) begin
        got_r = hsf_pkg::result_t'(out_tdata[hsf_pkg::RESULT_BITS-1:0]);
        if (pending_readings.size() == 0) begin
          failures++;
          $display("%0t: result item expected none got status %0d temp %0d", $time,
                   got_r.status, got_r.temperature_centi);
        end else begin
          want_r = pending_readings.pop_front();
          compare_field("status", want_r.status, got_r.status);
          compare_field("temperature_centi", want_r.temperature_centi,
                        got_r.temperature_centi);
          compare_field("humidity_centi", want_r.humidity_centi, got_r.humidity_centi);
          compare_field("held_last", want_r.held_last, got_r.held_last);
          compare_field("anomaly_run", want_r.anomaly_run, got_r.anomaly_run);
          compare_field("anomalies_seen", want_r.anomalies_seen, got_r.anomalies_seen);
          compare_field("errors_seen", want_r.errors_seen, got_r.errors_seen);
          compare_field("samples_seen", want_r.samples_seen, got_r.samples_seen);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // hang detector
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------

  // present one item, with a random gap when a burst runs out
  task automatic send_item(hsf_pkg::sample_t s, stim_row_t tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    pinned_values.push_back(tag);
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop sending and let every expected item come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0 || pinned_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers back to back, block idle
  task automatic load_config(int jl, int mr, int tmin, int tmax);
    logic [hsf_pkg::CFG_DATA_BITS-1:0] vals [4];
    hsf_pkg::cfg_idx_t idx;
    vals = '{jl[14:0], mr[14:0], tmin[14:0], tmax[14:0]};
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= vals[idx];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we   <= 1'b0;
    jump_lim = jl[13:0];
    run_cap  = mr[3:0];
    t_lo     = tmin[14:0];
    t_hi     = tmax[14:0];
  endtask

  // mostly a drifting sensor with valid frames, plus spikes, noise and bad crcs
  task automatic run_random(int n);
    int pick;
    logic [7:0] tf, hf;
    stim_row_t untagged;
    untagged.fixed = 1'b0;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      tf = 8'h00;
      hf = 8'h00;
      if (pick < 12) begin
        // any content at all
        walk_t = 16'($urandom_range(0, 16'hFFFF));
        walk_h = 16'($urandom_range(0, 16'hFFFF));
      end else if (pick < 22) begin
        // spike on one channel
        if ($urandom_range(0, 1)) walk_t = 16'($urandom_range(0, 16'hFFFF));
        else walk_h = 16'($urandom_range(0, 16'hFFFF));
      end else begin
        // slow drift, roughly the default jump limit per item
        walk_t = walk_t + 16'($urandom_range(0, 3000)) - 16'd1500;
        walk_h = walk_h + 16'($urandom_range(0, 3000)) - 16'd1500;
      end
      if (pick >= 88 && pick < 94) tf = 8'($urandom_range(1, 255));
      else if (pick >= 94) hf = 8'($urandom_range(1, 255));
      send_item(frame_item(walk_t, walk_h, tf, hf), untagged);
    end
  endtask

  // directed items under reset configuration (jump 300, run 3, -40.00..125.00)
  stim_row_t directed_rows [19] = '{
    // errors before any good pair report zero, zero
    '{16'h8000, 16'h0000, 8'h01, 8'h00, 1'b1, hsf_pkg::STATUS_TEMP_CRC, 0, 0},
    '{16'h8000, 16'h0000, 8'h00, 8'h01, 1'b1, hsf_pkg::STATUS_HUM_CRC, 0, 0},
    // coldest and hottest raw words, both out of range
    '{16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_RANGE, 0, 0},
    '{16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_RANGE, 0, 0},
    // first good pair, humidity clamped at zero
    '{16'h8000, 16'h0000, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_OK, 4101, 0},
    // humidity jumps to full scale: held three times, taken on the fourth
    '{16'h8000, 16'hFFFF, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_OK, 4101, 0},
    '{16'h8000, 16'hFFFF, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_OK, 4101, 0},
    '{16'h8000, 16'hFFFF, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_OK, 4101, 0},
    '{16'h8000, 16'hFFFF, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_OK, 4101, 10000},
    // status bits in the low word are ignored, then a temperature crc error
    '{16'h8003, 16'hFFFE, 8'h00, 8'h00, 1'b1, hsf_pkg::STATUS_OK, 4101, 10000},
    '{16'h8000, 16'hFFFF, 8'hFF, 8'h00, 1'b1, hsf_pkg::STATUS_TEMP_CRC, 4101, 10000},
    '{16'h8100, 16'hFFFF, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    // temperature spike, then a crc error inside the run
    '{16'hC000, 16'hFFFF, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    '{16'hC000, 16'h4000, 8'h00, 8'h80, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    '{16'h8100, 16'h4000, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    // on and just past both range limits
    '{16'h09FC, 16'h4000, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    '{16'h09F8, 16'h4000, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    '{16'hFA60, 16'h4000, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0},
    '{16'hFA64, 16'h4000, 8'h00, 8'h00, 1'b0, hsf_pkg::STATUS_OK, 0, 0}
  };

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= hsf_pkg::CFG_JUMP_LIMIT;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(frame_item(directed_rows[i].t_word, directed_rows[i].h_word,
                           directed_rows[i].t_flip, directed_rows[i].h_flip),
                directed_rows[i]);
    end
    wait_drained();

    // zero jump limit and zero run: every change is an anomaly, taken at once
    load_config(0, 0, -4685, 12887);
    run_random(60);
    wait_drained();

    // widest limits, longest run
    load_config(16383, 15, -4685, 12887);
    run_random(50);
    wait_drained();

    // zero limit with longest run: run climbs to fifteen before the jump is taken
    load_config(0, 15, -4685, 12887);
    run_random(60);
    wait_drained();

    // crossed limits, every valid reading out of range
    load_config(300, 3, 12887, -4685);
    run_random(30);
    wait_drained();

    repeat (5) begin
      load_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                             : $urandom_range(0, 1500),
                  $urandom_range(0, 15),
                  int'($urandom_range(0, 6000)) - 4685,
                  int'($urandom_range(6000, 17572)) - 4685);
      run_random(60);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
